### sv/qvr_pkg.sv
// Shared widths, types and divider sizing for the quaternion vector rotator.
// No dependencies.
package qvr_pkg;

   localparam int QIN_W     = 16;
   localparam int VEC_W     = 32;
   localparam int PRD_W     = 2 * QIN_W;
   localparam int MAT_W     = PRD_W + 2;
   localparam int MUL_W     = MAT_W + VEC_W;
   localparam int NUM_W     = MUL_W + 2;
   localparam int NRM_W     = PRD_W + 1;
   localparam int QUO_W     = VEC_W;
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   typedef logic signed [VEC_W-1:0] vec_type [3];

   typedef struct packed {
      logic [2:0]             neg;
      logic [3*VEC_W-1:0]     vec;
      logic [NRM_W-1:0]       nrm;
      logic                   degenerate;
   } side_type;

endpackage

### sv/quaternion_vector_rotate.sv
// Quaternion vector rotator: v' = M(q) v / |q|^2, rounded and saturated to Q16.16.
// Depends on qvr_pkg and qvr_div.
//
//   channel | direction | handshake           | beat
//   req     | in        | req_valid/req_stall | quaternion Q4.12 + vector Q16.16
//   rsp     | out       | rsp_valid/rsp_stall | rotated vector + clipped, degenerate
//
// One beat per cycle sustained while rsp is not stalled.
// The divider pipeline produces two quotient bits per stage.
// Reset (synchronous) clears only the valid bits.
// A stall on rsp while rsp_valid is high freezes the whole pipeline and stalls req in the same cycle.
module quaternion_vector_rotate import qvr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [QIN_W-1:0] req_quat_w,
   input  logic signed [QIN_W-1:0] req_quat_x,
   input  logic signed [QIN_W-1:0] req_quat_y,
   input  logic signed [QIN_W-1:0] req_quat_z,
   input  logic signed [VEC_W-1:0] req_vec_x,
   input  logic signed [VEC_W-1:0] req_vec_y,
   input  logic signed [VEC_W-1:0] req_vec_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VEC_W-1:0] rsp_rot_x,
   output logic signed [VEC_W-1:0] rsp_rot_y,
   output logic signed [VEC_W-1:0] rsp_rot_z,
   output logic                    rsp_clipped,
   output logic                    rsp_degenerate
);

   localparam int PIPE = 5 + DIV_STAGES;

   logic advance;
   logic vld_ff [PIPE];

   // stage 1: input capture
   logic signed [QIN_W-1:0] q_ff [4];
   vec_type                 v1_ff;
   // stage 2: quaternion products ss xx yy zz xy xz yz sx sy sz
   logic signed [PRD_W-1:0] p_ff [10];
   logic signed [PRD_W-1:0] p_in [10];
   vec_type                 v2_ff;
   // stage 3: matrix and norm
   logic signed [MAT_W-1:0] m_ff [9];
   logic signed [MAT_W-1:0] m_in [9];
   logic [NRM_W-1:0]        n3_ff, n3_in;
   logic                    dg3_ff;
   vec_type                 v3_ff;
   // stage 4: matrix times vector
   logic signed [MUL_W-1:0] mv_ff [9];
   logic signed [MUL_W-1:0] mv_in [9];
   logic [NRM_W-1:0]        n4_ff;
   logic                    dg4_ff;
   vec_type                 v4_ff;
   // stage 5: row sums as sign and magnitude
   logic [NUM_W-1:0]        a_ff [3];
   logic [NUM_W-1:0]        a_in [3];
   logic [2:0]              neg_ff, neg_in;
   logic [NRM_W-1:0]        n5_ff;
   logic                    dg5_ff;
   vec_type                 v5_ff;
   // divider sideband
   side_type                side_ff [DIV_STAGES];
   side_type                side_in;
   logic [QUO_W-1:0]        quo [3];
   logic [NRM_W-1:0]        rem [3];
   // output
   logic signed [VEC_W-1:0] rot_ff [3];
   logic signed [VEC_W-1:0] rot_in [3];
   logic                    clip_ff, clip_in;
   logic                    dgo_ff;
   logic                    out_vld_ff;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE; k++) vld_ff[k] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE; k++) vld_ff[k] <= vld_ff[k-1];
         out_vld_ff <= vld_ff[PIPE-1];
      end
   end

   always_comb begin
      p_in[0] = q_ff[0] * q_ff[0];
      p_in[1] = q_ff[1] * q_ff[1];
      p_in[2] = q_ff[2] * q_ff[2];
      p_in[3] = q_ff[3] * q_ff[3];
      p_in[4] = q_ff[1] * q_ff[2];
      p_in[5] = q_ff[1] * q_ff[3];
      p_in[6] = q_ff[2] * q_ff[3];
      p_in[7] = q_ff[0] * q_ff[1];
      p_in[8] = q_ff[0] * q_ff[2];
      p_in[9] = q_ff[0] * q_ff[3];
   end

   always_comb begin
      m_in[0] = MAT_W'(p_ff[0]) + MAT_W'(p_ff[1]) - MAT_W'(p_ff[2]) - MAT_W'(p_ff[3]);
      m_in[1] = (MAT_W'(p_ff[4]) - MAT_W'(p_ff[9])) <<< 1;
      m_in[2] = (MAT_W'(p_ff[5]) + MAT_W'(p_ff[8])) <<< 1;
      m_in[3] = (MAT_W'(p_ff[4]) + MAT_W'(p_ff[9])) <<< 1;
      m_in[4] = MAT_W'(p_ff[0]) - MAT_W'(p_ff[1]) + MAT_W'(p_ff[2]) - MAT_W'(p_ff[3]);
      m_in[5] = (MAT_W'(p_ff[6]) - MAT_W'(p_ff[7])) <<< 1;
      m_in[6] = (MAT_W'(p_ff[5]) - MAT_W'(p_ff[8])) <<< 1;
      m_in[7] = (MAT_W'(p_ff[6]) + MAT_W'(p_ff[7])) <<< 1;
      m_in[8] = MAT_W'(p_ff[0]) - MAT_W'(p_ff[1]) - MAT_W'(p_ff[2]) + MAT_W'(p_ff[3]);
      n3_in = NRM_W'(unsigned'(p_ff[0])) + NRM_W'(unsigned'(p_ff[1]))
            + NRM_W'(unsigned'(p_ff[2])) + NRM_W'(unsigned'(p_ff[3]));
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mv_in[r*3+c] = MUL_W'(m_ff[r*3+c]) * MUL_W'(v3_ff[c]);
         end
      end
   end

   always_comb begin
      logic signed [NUM_W-1:0] sum;
      for (int r = 0; r < 3; r++) begin
         sum = NUM_W'(mv_ff[r*3]) + NUM_W'(mv_ff[r*3+1]) + NUM_W'(mv_ff[r*3+2]);
         neg_in[r] = sum[NUM_W-1];
         a_in[r]   = neg_in[r] ? unsigned'(-sum) : unsigned'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[0] <= req_quat_w;
         q_ff[1] <= req_quat_x;
         q_ff[2] <= req_quat_y;
         q_ff[3] <= req_quat_z;
         v1_ff[0] <= req_vec_x;
         v1_ff[1] <= req_vec_y;
         v1_ff[2] <= req_vec_z;
         p_ff  <= p_in;
         v2_ff <= v1_ff;
         m_ff  <= m_in;
         n3_ff <= n3_in;
         dg3_ff <= (n3_in == '0);
         v3_ff <= v2_ff;
         mv_ff <= mv_in;
         n4_ff <= n3_ff;
         dg4_ff <= dg3_ff;
         v4_ff <= v3_ff;
         a_ff   <= a_in;
         neg_ff <= neg_in;
         n5_ff  <= n4_ff;
         dg5_ff <= dg4_ff;
         v5_ff  <= v4_ff;
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STAGES; k++) side_ff[k] <= side_ff[k-1];
         rot_ff  <= rot_in;
         clip_ff <= clip_in;
         dgo_ff  <= side_ff[DIV_STAGES-1].degenerate;
      end
   end

   assign side_in = '{neg: neg_ff, vec: {v5_ff[2], v5_ff[1], v5_ff[0]},
                      nrm: n5_ff, degenerate: dg5_ff};

   for (genvar r = 0; r < 3; r++) begin : g_lane
      qvr_div u_div (
         .clock (clock),
         .en    (advance),
         .num   (a_ff[r]),
         .den   (n5_ff),
         .quo   (quo[r]),
         .rem   (rem[r])
      );
   end

   always_comb begin
      side_type         sd;
      logic [QUO_W:0]   mag;
      logic             up;
      sd = side_ff[DIV_STAGES-1];
      clip_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         up  = {rem[r], 1'b0} >= {1'b0, sd.nrm};
         mag = {1'b0, quo[r]} + (QUO_W+1)'(up);
         if (sd.degenerate) begin
            rot_in[r] = signed'(sd.vec[r*VEC_W +: VEC_W]);
         end else if (sd.neg[r]) begin
            if (mag > (QUO_W+1)'(33'h080000000)) begin
               clip_in   = 1'b1;
               rot_in[r] = signed'(32'h80000000);
            end else begin
               rot_in[r] = signed'(VEC_W'(~mag + 1'b1));
            end
         end else begin
            if (mag > (QUO_W+1)'(33'h07FFFFFFF)) begin
               clip_in   = 1'b1;
               rot_in[r] = signed'(32'h7FFFFFFF);
            end else begin
               rot_in[r] = signed'(mag[VEC_W-1:0]);
            end
         end
      end
      if (sd.degenerate) clip_in = 1'b0;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_rot_x      = rot_ff[0];
   assign rsp_rot_y      = rot_ff[1];
   assign rsp_rot_z      = rot_ff[2];
   assign rsp_clipped    = clip_ff;
   assign rsp_degenerate = dgo_ff;

   a_deg_no_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_clipped)
      else $error("degenerate beat flagged clipped");

   a_stall_path: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output backpressure");

   a_out_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(vld_ff[PIPE-1]))
      else $error("output valid without a beat in the last stage");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff[PIPE-1]))
      else $error("pipeline moved while stalled");

endmodule

### sv/qvr_div.sv
// Pipelined restoring divider, DIV_STEPS quotient bits per stage, no stall logic
// beyond a shared enable. Depends on qvr_pkg.
module qvr_div import qvr_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [NRM_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic [NRM_W-1:0] rem
);

   logic [NRM_W-1:0] rem_ff [DIV_STAGES];
   logic [NRM_W-1:0] rem_in [DIV_STAGES];
   logic [QUO_W-1:0] low_ff [DIV_STAGES];
   logic [QUO_W-1:0] low_in [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_in [DIV_STAGES];
   logic [NRM_W-1:0] den_ff [DIV_STAGES];
   logic [NRM_W-1:0] den_in [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int PREV = (k == 0) ? 0 : k - 1;

      always_comb begin
         logic [NRM_W-1:0] r;
         logic [QUO_W-1:0] l;
         logic [QUO_W-1:0] q;
         logic [NRM_W:0]   t;
         if (k == 0) begin
            r = NRM_W'(num[NUM_W-1:QUO_W]);
            l = num[QUO_W-1:0];
            q = '0;
            den_in[k] = den;
         end else begin
            r = rem_ff[PREV];
            l = low_ff[PREV];
            q = quo_ff[PREV];
            den_in[k] = den_ff[PREV];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            t = {r, l[QUO_W-1]};
            l = {l[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, den_in[k]}) begin
               t = t - {1'b0, den_in[k]};
               q = {q[QUO_W-2:0], 1'b1};
            end else begin
               q = {q[QUO_W-2:0], 1'b0};
            end
            r = t[NRM_W-1:0];
         end
         rem_in[k] = r;
         low_in[k] = l;
         quo_in[k] = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];
   assign rem = rem_ff[DIV_STAGES-1];

endmodule

### tb/quaternion_vector_rotate_test.sv
// Testbench for quaternion_vector_rotate: directed and random quaternion/vector beats,
// bursty sender and stalling receiver, results checked against an exact predictor.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
module quaternion_vector_rotate_test;
   import qvr_pkg::*;

   typedef struct {
      logic signed [QIN_W-1:0] qw, qx, qy, qz;
      logic signed [VEC_W-1:0] vx, vy, vz;
   } rot_req_type;

   typedef struct {
      logic signed [VEC_W-1:0] rx, ry, rz;
      logic                    clipped, degenerate;
   } rot_rsp_type;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic signed [QIN_W-1:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [VEC_W-1:0] req_vec_x = 0, req_vec_y = 0, req_vec_z = 0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic signed [VEC_W-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic                    rsp_clipped, rsp_degenerate;

   rot_req_type pending_beats[$];
   rot_rsp_type expected_rots[$];
   int          mismatches = 0;
   bit          stimulus_done = 0;
   bit          req_accepted = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;

   quaternion_vector_rotate dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // exact rotation: numerator to 128 bits, divide by |q|^2, round half away, saturate
   function automatic logic signed [VEC_W-1:0] scale_sat(logic signed [127:0] num,
                                                          logic signed [127:0] nrm,
                                                          inout logic clip);
      logic signed [127:0] mag, quo, rem;
      logic                neg;
      neg = num < 0;
      mag = neg ? -num : num;
      quo = mag / nrm;
      rem = mag % nrm;
      if (2 * rem >= nrm) quo = quo + 1;
      if (neg) begin
         if (quo > 128'sh80000000) begin
            clip = 1;
            quo = 128'sh80000000;
         end
         return VEC_W'(-quo);
      end
      if (quo > 128'sh7FFFFFFF) begin
         clip = 1;
         quo = 128'sh7FFFFFFF;
      end
      return VEC_W'(quo);
   endfunction

   function automatic rot_rsp_type rotate_vector(rot_req_type b);
      logic signed [127:0] s, x, y, z, n, vx, vy, vz;
      logic signed [127:0] m[3][3];
      logic signed [127:0] acc;
      logic                clip;
      rot_rsp_type         r;
      s = b.qw; x = b.qx; y = b.qy; z = b.qz;
      vx = b.vx; vy = b.vy; vz = b.vz;
      n = s * s + x * x + y * y + z * z;
      clip = 0;
      if (n == 0) begin
         r.rx = b.vx; r.ry = b.vy; r.rz = b.vz;
         r.clipped = 0;
         r.degenerate = 1;
         return r;
      end
      m[0][0] = s * s + x * x - y * y - z * z;
      m[0][1] = 2 * (x * y - s * z);
      m[0][2] = 2 * (x * z + s * y);
      m[1][0] = 2 * (x * y + s * z);
      m[1][1] = s * s - x * x + y * y - z * z;
      m[1][2] = 2 * (y * z - s * x);
      m[2][0] = 2 * (x * z - s * y);
      m[2][1] = 2 * (y * z + s * x);
      m[2][2] = s * s - x * x - y * y + z * z;
      acc = m[0][0] * vx + m[0][1] * vy + m[0][2] * vz;
      r.rx = scale_sat(acc, n, clip);
      acc = m[1][0] * vx + m[1][1] * vy + m[1][2] * vz;
      r.ry = scale_sat(acc, n, clip);
      acc = m[2][0] * vx + m[2][1] * vy + m[2][2] * vz;
      r.rz = scale_sat(acc, n, clip);
      r.clipped = clip;
      r.degenerate = 0;
      return r;
   endfunction

   function automatic logic signed [QIN_W-1:0] rand_quat_part();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 0;
         3: return QIN_W'($urandom_range(0, 8192)) - 16'sd4096;
         default: return QIN_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [VEC_W-1:0] rand_vec_part();
      case ($urandom_range(0, 5))
         0: return 32'sh80000000;
         1: return 32'sh7FFFFFFF;
         2: return 0;
         3: return VEC_W'($urandom_range(0, 2000000)) - 32'sd1000000;
         default: return VEC_W'($urandom);
      endcase
   endfunction

   task automatic queue_beat(logic signed [QIN_W-1:0] qw, qx, qy, qz,
                             logic signed [VEC_W-1:0] vx, vy, vz);
      rot_req_type b;
      b.qw = qw; b.qx = qx; b.qy = qy; b.qz = qz;
      b.vx = vx; b.vy = vy; b.vz = vz;
      pending_beats.push_back(b);
   endtask

   initial begin
      rot_req_type b;
      // zero quaternion passes through
      queue_beat(0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678);
      queue_beat(0, 0, 0, 0, 0, -1, 1);
      // identity and unnormalized identity
      queue_beat(16'sh1000, 0, 0, 0, 32'sh00010000, 32'sh00020000, -32'sh00030000);
      queue_beat(16'sh7FFF, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 5);
      queue_beat(16'sh8000, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, -5);
      // half turns about each axis
      queue_beat(0, 16'sh1000, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      queue_beat(0, 0, 16'sh8000, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      queue_beat(0, 0, 0, 16'sh7FFF, 1, 2, 3);
      // quarter turns and turns about a diagonal: saturation on large vectors
      queue_beat(16'sh1000, 16'sh1000, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      queue_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      queue_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
      queue_beat(16'sh1000, 0, 0, 16'sh1000, 32'sh80000000, 32'sh80000000, 0);
      // tiny quaternions, rounding ties
      queue_beat(0, 0, 0, 1, 1, 1, 1);
      queue_beat(1, 1, 0, 0, 1, 3, -3);
      queue_beat(-1, 1, 1, -1, -1, 1, 3);
      queue_beat(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, -1, -1, -1);
      repeat (1400) begin
         b.qw = rand_quat_part(); b.qx = rand_quat_part();
         b.qy = rand_quat_part(); b.qz = rand_quat_part();
         if ($urandom_range(0, 29) == 0) {b.qw, b.qx, b.qy, b.qz} = '0;
         b.vx = rand_vec_part(); b.vy = rand_vec_part(); b.vz = rand_vec_part();
         pending_beats.push_back(b);
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // sender: bursts with random gaps, payload held until the beat is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_accepted)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else if (pending_beats.size() > 0) begin
            rot_req_type b;
            b = pending_beats.pop_front();
            req_valid <= 1;
            req_quat_w <= b.qw; req_quat_x <= b.qx;
            req_quat_y <= b.qy; req_quat_z <= b.qz;
            req_vec_x <= b.vx; req_vec_y <= b.vy; req_vec_z <= b.vz;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 0;
            stimulus_done <= 1;
         end
      end
   end

   // receiver stall pattern, changing character every so often
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         rot_req_type b;
         b.qw = req_quat_w; b.qx = req_quat_x; b.qy = req_quat_y; b.qz = req_quat_z;
         b.vx = req_vec_x; b.vy = req_vec_y; b.vz = req_vec_z;
         expected_rots.push_back(rotate_vector(b));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rot_rsp_type e;
         if (expected_rots.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            e = expected_rots.pop_front();
            if (e.rx !== rsp_rot_x || e.ry !== rsp_rot_y || e.rz !== rsp_rot_z
                || e.clipped !== rsp_clipped || e.degenerate !== rsp_degenerate) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d c%0b d%0b got %0d %0d %0d c%0b d%0b",
                           e.rx, e.ry, e.rz, e.clipped, e.degenerate,
                           rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_clipped, rsp_degenerate);
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_rots.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_rots.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
